[hdl/dnsqs_pkg.sv]
`default_nettype none
package dnsqs_pkg;

  localparam int unsigned HEADER_BYTES = 12;
  localparam int unsigned POS_W = 16;
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [15:0] FLAG_QR     = 16'h8000;
  localparam logic [15:0] FLAG_OPCODE = 16'h7800;
  localparam logic [15:0] FLAG_TC     = 16'h0200;
  localparam logic [15:0] FLAG_Z      = 16'h0040;
  localparam logic [15:0] FLAG_MASK   = FLAG_QR | FLAG_OPCODE | FLAG_TC | FLAG_Z;

  // header word positions (index of the low byte)
  localparam logic [POS_W-1:0] POS_FLAGS   = POS_W'(3);
  localparam logic [POS_W-1:0] POS_QDCOUNT = POS_W'(5);
  localparam logic [POS_W-1:0] POS_ANCOUNT = POS_W'(7);
  localparam logic [POS_W-1:0] POS_NSCOUNT = POS_W'(9);
  localparam logic [POS_W-1:0] POS_HDR_END = POS_W'(HEADER_BYTES - 1);
  localparam logic [POS_W-1:0] POS_HDR_LEN = POS_W'(HEADER_BYTES);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ALERT_LABEL_LENGTH = 8'd0,
    REG_ALERT_MIN_LEVELS   = 8'd1
  } cfg_reg_t;

  localparam logic [5:0] ALERT_LABEL_LENGTH_RESET = 6'd1;
  localparam logic [7:0] ALERT_MIN_LEVELS_RESET   = 8'd2;

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_LEN    = 5'b00010,
    PH_BODY   = 5'b00100,
    PH_TAIL   = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       is_last;
  } in_beat_t;

  typedef struct packed {
    logic        alert;
    logic        header_accepted;
    logic        name_complete;
    logic [7:0]  final_label_length;
    logic [7:0]  label_levels;
    logic [15:0] query_type;
    logic [15:0] query_class;
  } out_beat_t;

endpackage
`default_nettype wire

[hdl/dns_query_name_screen.sv]
// DNS query name screen. Takes a DNS message one byte per beat (is_last marks the final
// byte) and returns one result beat per message: header checks (length >= 13, one question,
// no answers or nameservers, standard-query flags), the label count of the question name
// (saturating at 255), the last label length, and the type and class words. alert is set when
// the header passes, the name and type/class fit in the message, the last label length equals
// register 0 and the label count is at least register 1. One byte is accepted every clock
// unless in_stall is high; the per-byte parse state is updated in the cycle the byte is
// accepted, and the result is registered as the last byte is accepted. in_stall is raised
// only while a result sits in the output register under out_stall. cfg_ready is always high.
`default_nettype none
module dns_query_name_screen (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output      logic                                in_stall,
  input  wire dnsqs_pkg::in_beat_t                 in_beat,
  output      logic                                out_valid,
  input  wire logic                                out_stall,
  output      dnsqs_pkg::out_beat_t                out_beat,
  input  wire logic                                cfg_valid,
  output      logic                                cfg_ready,
  input  wire logic [dnsqs_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [dnsqs_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import dnsqs_pkg::*;

  logic [5:0]       alert_label_length;
  logic [7:0]       alert_min_levels;

  logic [POS_W-1:0] byte_position, byte_position_next;
  phase_t           phase, phase_next;
  logic [7:0]       high_byte_hold, high_byte_hold_next;
  logic             header_good, header_good_next;
  logic [7:0]       label_bytes_left, label_bytes_left_next;
  logic [7:0]       last_label_len, last_label_len_next;
  logic [7:0]       level_count, level_count_next;
  logic [31:0]      type_class_word, type_class_word_next;
  logic [2:0]       tail_count, tail_count_next;

  logic             in_take;
  logic             msg_end;
  logic [15:0]      hdr_word;
  logic             hdr_ok;
  logic             complete;
  out_beat_t        result;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign in_take   = in_valid & ~in_stall;
  assign msg_end   = in_take & in_beat.is_last;
  assign hdr_word  = {high_byte_hold, in_beat.packet_byte};

  always_comb begin
    byte_position_next    = byte_position;
    phase_next            = phase;
    high_byte_hold_next   = high_byte_hold;
    header_good_next      = header_good;
    label_bytes_left_next = label_bytes_left;
    last_label_len_next   = last_label_len;
    level_count_next      = level_count;
    type_class_word_next  = type_class_word;
    tail_count_next       = tail_count;

    unique case (phase)
      PH_HEADER: begin
        if (!byte_position[0]) begin
          high_byte_hold_next = in_beat.packet_byte;
        end else if (byte_position == POS_FLAGS) begin
          if ((hdr_word & FLAG_MASK) != 16'h0000) header_good_next = 1'b0;
        end else if (byte_position == POS_QDCOUNT) begin
          if (hdr_word != 16'h0001) header_good_next = 1'b0;
        end else if (byte_position == POS_ANCOUNT || byte_position == POS_NSCOUNT) begin
          if (hdr_word != 16'h0000) header_good_next = 1'b0;
        end
        if (byte_position >= POS_HDR_END) phase_next = PH_LEN;
      end
      PH_LEN: begin
        if (in_beat.packet_byte == 8'd0) begin
          phase_next = PH_TAIL;
        end else begin
          if (level_count != 8'hFF) level_count_next = level_count + 8'd1;
          last_label_len_next   = in_beat.packet_byte;
          label_bytes_left_next = in_beat.packet_byte;
          phase_next            = PH_BODY;
        end
      end
      PH_BODY: begin
        label_bytes_left_next = label_bytes_left - 8'd1;
        if (label_bytes_left == 8'd1) phase_next = PH_LEN;
      end
      PH_TAIL: begin
        type_class_word_next = {type_class_word[23:0], in_beat.packet_byte};
        tail_count_next      = tail_count + 3'd1;
        if (tail_count >= 3'd3) phase_next = PH_DONE;
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase

    if (byte_position != {POS_W{1'b1}}) byte_position_next = byte_position + POS_W'(1);
  end

  always_comb begin
    hdr_ok   = header_good_next && (byte_position >= POS_HDR_LEN);
    complete = (phase_next == PH_DONE);
    result.alert = hdr_ok && complete &&
                   (last_label_len_next == {2'b00, alert_label_length}) &&
                   (level_count_next >= alert_min_levels);
    result.header_accepted    = hdr_ok;
    result.name_complete      = complete;
    result.final_label_length = last_label_len_next;
    result.label_levels       = level_count_next;
    result.query_type         = complete ? type_class_word_next[31:16] : 16'h0000;
    result.query_class        = complete ? type_class_word_next[15:0] : 16'h0000;
  end

  always_ff @(posedge clk) begin
    if (rst || msg_end) begin
      byte_position    <= '0;
      phase            <= PH_HEADER;
      high_byte_hold   <= '0;
      header_good      <= 1'b1;
      label_bytes_left <= '0;
      last_label_len   <= '0;
      level_count      <= '0;
      type_class_word  <= '0;
      tail_count       <= '0;
    end else if (in_take) begin
      byte_position    <= byte_position_next;
      phase            <= phase_next;
      high_byte_hold   <= high_byte_hold_next;
      header_good      <= header_good_next;
      label_bytes_left <= label_bytes_left_next;
      last_label_len   <= last_label_len_next;
      level_count      <= level_count_next;
      type_class_word  <= type_class_word_next;
      tail_count       <= tail_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alert_label_length <= ALERT_LABEL_LENGTH_RESET;
      alert_min_levels   <= ALERT_MIN_LEVELS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ALERT_LABEL_LENGTH: alert_label_length <= cfg_data[5:0];
        REG_ALERT_MIN_LEVELS:   alert_min_levels   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (msg_end) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (msg_end) out_beat <= result;
  end

  a_alert_needs_checks: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_beat.alert ||
                   (out_beat.header_accepted && out_beat.name_complete)))
    else $error("alert without passing header and complete name");

  a_incomplete_zero_words: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_beat.name_complete) |->
      (out_beat.query_type == 16'h0000 && out_beat.query_class == 16'h0000))
    else $error("type/class reported for incomplete name");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    msg_end |=> (phase == PH_HEADER && byte_position == '0 && level_count == '0))
    else $error("parse state not cleared after last byte");

  a_result_follows_last: assert property (@(posedge clk) disable iff (rst)
    msg_end |=> out_valid)
    else $error("no result after last byte");

endmodule
`default_nettype wire

[sim/tb.sv]
class query_screen_check;
  bit [5:0] alert_len;
  bit [7:0] alert_levels;

  bit [15:0] pos;
  dnsqs_pkg::phase_t phase;
  bit [7:0] hi_byte;
  bit hdr_good;
  bit [7:0] body_left;
  bit [7:0] last_len;
  bit [7:0] levels;
  bit [31:0] tc_word;
  bit [2:0] tail_n;

  dnsqs_pkg::out_beat_t awaited[$];
  int errors, results, alerts, hdr_passes, complete_names;

  function new();
    alert_len = dnsqs_pkg::ALERT_LABEL_LENGTH_RESET;
    alert_levels = dnsqs_pkg::ALERT_MIN_LEVELS_RESET;
    clear_msg();
  endfunction

  function void clear_msg();
    pos = '0;
    phase = dnsqs_pkg::PH_HEADER;
    hi_byte = '0;
    hdr_good = 1'b1;
    body_left = '0;
    last_len = '0;
    levels = '0;
    tc_word = '0;
    tail_n = '0;
  endfunction

  function void write_reg(dnsqs_pkg::cfg_reg_t idx, bit [7:0] data);
    case (idx)
      dnsqs_pkg::REG_ALERT_LABEL_LENGTH: alert_len = data[5:0];
      dnsqs_pkg::REG_ALERT_MIN_LEVELS: alert_levels = data;
      default: ;
    endcase
  endfunction

  function int pending();
    return awaited.size();
  endfunction

  // one accepted byte; a beat marked last closes the message
  function void note_beat(dnsqs_pkg::in_beat_t beat);
    bit [15:0] at;
    bit [15:0] word;
    bit [7:0] b;
    bit hdr_ok, done;
    dnsqs_pkg::out_beat_t r;
    at = pos;
    b = beat.packet_byte;
    word = {hi_byte, b};
    case (phase)
      dnsqs_pkg::PH_HEADER: begin
        if (!at[0]) begin
          hi_byte = b;
        end else if (at == dnsqs_pkg::POS_FLAGS) begin
          if ((word & dnsqs_pkg::FLAG_MASK) != 16'd0) hdr_good = 1'b0;
        end else if (at == dnsqs_pkg::POS_QDCOUNT) begin
          if (word != 16'd1) hdr_good = 1'b0;
        end else if (at == dnsqs_pkg::POS_ANCOUNT || at == dnsqs_pkg::POS_NSCOUNT) begin
          if (word != 16'd0) hdr_good = 1'b0;
        end
        if (at >= dnsqs_pkg::POS_HDR_END) phase = dnsqs_pkg::PH_LEN;
      end
      dnsqs_pkg::PH_LEN: begin
        if (b == 8'd0) begin
          phase = dnsqs_pkg::PH_TAIL;
        end else begin
          if (levels != 8'hFF) levels++;
          last_len = b;
          body_left = b;
          phase = dnsqs_pkg::PH_BODY;
        end
      end
      dnsqs_pkg::PH_BODY: begin
        body_left--;
        if (body_left == 8'd0) phase = dnsqs_pkg::PH_LEN;
      end
      dnsqs_pkg::PH_TAIL: begin
        tc_word = {tc_word[23:0], b};
        tail_n++;
        if (tail_n >= 3'd4) phase = dnsqs_pkg::PH_DONE;
      end
      default: ;
    endcase
    if (pos != 16'hFFFF) pos++;
    if (!beat.is_last) return;

    hdr_ok = hdr_good && at >= dnsqs_pkg::POS_HDR_LEN;
    done = phase == dnsqs_pkg::PH_DONE;
    r.alert = hdr_ok && done && last_len == {2'b00, alert_len} && levels >= alert_levels;
    r.header_accepted = hdr_ok;
    r.name_complete = done;
    r.final_label_length = last_len;
    r.label_levels = levels;
    r.query_type = done ? tc_word[31:16] : 16'd0;
    r.query_class = done ? tc_word[15:0] : 16'd0;
    awaited.push_back(r);
    clear_msg();
  endfunction

  function void compare(string nm, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h, got %0h", $time, nm, want, got);
    end
  endfunction

  function void check_result(dnsqs_pkg::out_beat_t got);
    dnsqs_pkg::out_beat_t want;
    if (awaited.size() == 0) begin
      errors++;
      $display("%0t: result beat expected none, got %p", $time, got);
      return;
    end
    want = awaited.pop_front();
    results++;
    alerts += want.alert;
    hdr_passes += want.header_accepted;
    complete_names += want.name_complete;
    compare("alert", want.alert, got.alert);
    compare("header_accepted", want.header_accepted, got.header_accepted);
    compare("name_complete", want.name_complete, got.name_complete);
    compare("final_label_length", want.final_label_length, got.final_label_length);
    compare("label_levels", want.label_levels, got.label_levels);
    compare("query_type", want.query_type, got.query_type);
    compare("query_class", want.query_class, got.query_class);
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dnsqs_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_beat = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_beat;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  query_screen_check screen;
  bit [7:0] msg[$];
  int tx_quiet, rx_quiet, long_hold;
  int bytes_sent, msgs_sent, settings;

  always #4 clk = ~clk;

  dns_query_name_screen u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_beat(in_beat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_beat(out_beat),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic send_beat(input bit [7:0] b, input bit last);
    int gap;
    in_beat_t beat;
    if (tx_quiet > 0) begin
      gap = 0;
      tx_quiet--;
    end else if ($urandom_range(0, 15) == 0) begin
      tx_quiet = $urandom_range(10, 40);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 9);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    beat.packet_byte = b;
    beat.is_last = last;
    in_valid <= 1'b1;
    in_beat <= beat;
    do @(posedge clk); while (in_stall !== 1'b0);
    screen.note_beat(beat);
    bytes_sent++;
  endtask

  task automatic send_msg();
    foreach (msg[i]) send_beat(msg[i], i == msg.size() - 1);
    msgs_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (screen.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(input bit [5:0] len, input bit [7:0] lvl);
    bit [7:0] data;
    data = {2'($urandom_range(0, 3)), len};
    cfg_valid <= 1'b1;
    cfg_index <= REG_ALERT_LABEL_LENGTH;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    screen.write_reg(REG_ALERT_LABEL_LENGTH, data);
    cfg_index <= REG_ALERT_MIN_LEVELS;
    cfg_data <= lvl;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    screen.write_reg(REG_ALERT_MIN_LEVELS, lvl);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  function automatic void build_query(int lvl, int last, bit good, int extra, int max_len);
    bit [15:0] flags, qd, an, ns;
    int n, bitn;
    msg.delete();
    flags = 16'($urandom) & ~FLAG_MASK;
    qd = 16'd1;
    an = 16'd0;
    ns = 16'd0;
    if (!good) begin
      case ($urandom_range(0, 3))
        0: begin
          do bitn = $urandom_range(0, 15); while (!FLAG_MASK[bitn]);
          flags[bitn] = 1'b1;
        end
        1: qd = $urandom_range(0, 1) ? 16'($urandom_range(2, 65535)) : 16'd0;
        2: an = 16'($urandom_range(1, 65535));
        default: ns = 16'($urandom_range(1, 65535));
      endcase
    end
    repeat (2) msg.push_back(8'($urandom));
    msg.push_back(flags[15:8]);
    msg.push_back(flags[7:0]);
    msg.push_back(qd[15:8]);
    msg.push_back(qd[7:0]);
    msg.push_back(an[15:8]);
    msg.push_back(an[7:0]);
    msg.push_back(ns[15:8]);
    msg.push_back(ns[7:0]);
    repeat (2) msg.push_back(8'($urandom));
    for (int i = 0; i < lvl; i++) begin
      n = (i == lvl - 1) ? last : $urandom_range(1, max_len);
      msg.push_back(8'(n));
      repeat (n) msg.push_back(8'($urandom));
    end
    msg.push_back(8'd0);
    repeat (4) msg.push_back(8'($urandom));
    repeat (extra) msg.push_back(8'($urandom));
  endfunction

  // mostly well-formed queries, some with a bad header, truncated, or plain noise
  task automatic random_msg();
    int kind, lvl, last, cut;
    kind = $urandom_range(0, 99);
    lvl = $urandom_range(0, 6);
    if ($urandom_range(0, 1)) last = screen.alert_len;
    else if ($urandom_range(0, 9) == 0) last = $urandom_range(1, 255);
    else last = $urandom_range(1, 63);
    if (last == 0) lvl = 0;
    if (kind < 85) begin
      build_query(lvl, last, kind < 55 || kind >= 70,
                  ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0,
                  ($urandom_range(0, 19) == 0) ? 255 : 8);
      if (kind >= 70) begin
        cut = $urandom_range(1, msg.size() - 1);
        while (msg.size() > cut) void'(msg.pop_back());
      end
    end else begin
      msg.delete();
      repeat ($urandom_range(1, 30)) msg.push_back(8'($urandom));
    end
    send_msg();
  endtask

  task automatic random_phase(input int budget);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < budget) random_msg();
  endtask

  initial begin : drain
    int w;
    forever begin
      if (long_hold != 0) begin
        w = 300;
        long_hold = 0;
      end else if (rx_quiet > 0) begin
        w = 0;
        rx_quiet--;
      end else if ($urandom_range(0, 15) == 0) begin
        rx_quiet = $urandom_range(5, 20);
        w = 0;
      end else begin
        w = $urandom_range(0, 9);
      end
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1 || rst);
      screen.check_result(out_beat);
    end
  end

  initial begin
    screen = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    msg = '{8'hFF};
    send_msg();
    build_query(2, 1, 1'b1, 0, 1);
    send_msg();
    settle();
    write_regs(6'd0, 8'd0);
    build_query(0, 0, 1'b1, 0, 1);
    send_msg();
    random_phase(150);

    settle();
    write_regs(6'd63, 8'd255);
    build_query(257, 63, 1'b1, 0, 1);
    send_msg();
    random_phase(150);

    for (int p = 0; p < 4; p++) begin
      settle();
      if (p == 3) write_regs(6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
      else write_regs(6'($urandom_range(1, 8)), 8'($urandom_range(0, 5)));
      if (p == 1) begin
        long_hold = 1;
        repeat (10) begin
          msg.delete();
          repeat ($urandom_range(1, 3)) msg.push_back(8'($urandom));
          send_msg();
        end
      end
      random_phase(150);
    end
    settle();

    $display("Sent %0d bytes in %0d messages across %0d register settings.",
             bytes_sent, msgs_sent, settings);
    $display("Checked %0d results: %0d alerts, %0d headers accepted, %0d complete names.",
             screen.results, screen.alerts, screen.hdr_passes, screen.complete_names);
    if (screen.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

[sim.f]
hdl/dnsqs_pkg.sv
hdl/dns_query_name_screen.sv
sim/tb.sv
